/* sv/assert_macros.svh */
// Assertion helpers shared by the region finder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define SRF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define SRF_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define SRF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* sv/srf_pkg.sv */
`default_nettype none

package srf_pkg;

  localparam int IDX_W  = 13;
  localparam int THR_W  = 16;
  localparam int PAD_W  = 13;
  localparam int LEN_W  = 14;
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_START_THR = 3'd0,
    REG_STOP_THR  = 3'd1,
    REG_PRE_PAD   = 3'd2,
    REG_POST_PAD  = 3'd3,
    REG_WIN_LEN   = 3'd4
  } reg_idx_t;

  localparam logic [THR_W-1:0] START_THR_RST = 16'd48;
  localparam logic [THR_W-1:0] STOP_THR_RST  = 16'd16;
  localparam logic [PAD_W-1:0] PAD_RST       = '0;
  localparam logic [LEN_W-1:0] WIN_LEN_RST   = 14'd4096;

  typedef struct packed {
    logic signed [THR_W-1:0] start_threshold;
    logic signed [THR_W-1:0] stop_threshold;
    logic [PAD_W-1:0]        pre_pad;
    logic [PAD_W-1:0]        post_pad;
    logic [LEN_W-1:0]        window_length;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] region_start;
    logic [IDX_W-1:0] region_end;
    logic             window_done;
  } region_t;

  // Up to two results per sample; r0 always precedes r1.
  typedef struct packed {
    logic    v0;
    region_t r0;
    logic    v1;
    region_t r1;
  } push_t;

endpackage

`default_nettype wire

/* sv/srf_regs.sv */
`default_nettype none

module srf_regs
  import srf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_threshold <= START_THR_RST;
      cfg.stop_threshold  <= STOP_THR_RST;
      cfg.pre_pad         <= PAD_RST;
      cfg.post_pad        <= PAD_RST;
      cfg.window_length   <= WIN_LEN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_START_THR: cfg.start_threshold <= pwdata[THR_W-1:0];
        REG_STOP_THR:  cfg.stop_threshold  <= pwdata[THR_W-1:0];
        REG_PRE_PAD:   cfg.pre_pad         <= pwdata[PAD_W-1:0];
        REG_POST_PAD:  cfg.post_pad        <= pwdata[PAD_W-1:0];
        REG_WIN_LEN:   cfg.window_length   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_THR: prdata = APB_DW'(cfg.start_threshold);
      REG_STOP_THR:  prdata = APB_DW'(cfg.stop_threshold);
      REG_PRE_PAD:   prdata = APB_DW'(cfg.pre_pad);
      REG_POST_PAD:  prdata = APB_DW'(cfg.post_pad);
      REG_WIN_LEN:   prdata = APB_DW'(cfg.window_length);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/srf_track.sv */
`default_nettype none

module srf_track
  import srf_pkg::*;
#(
  parameter int MAX_WINDOW   = 8192,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cfg_t                           cfg,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire logic                           room,
  output push_t                               push
);

  `include "assert_macros.svh"

  localparam int PW  = $clog2(MAX_WINDOW);
  localparam int LW  = $clog2(MAX_WINDOW + 1);
  localparam int CW  = (LW > LEN_W) ? LW : LEN_W;
  localparam int AW  = ((PW > PAD_W) ? PW : PAD_W) + 1;
  localparam int XW  = (SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W;

  // input register
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;

  // window state
  logic [PW-1:0] position, position_next;
  logic          region_open, region_open_next;
  logic [PW-1:0] open_start, open_start_next;
  logic          pend_v, pend_v_next;
  logic [PW-1:0] pend_s, pend_s_next;
  logic [PW-1:0] pend_e, pend_e_next;

  logic            fire, last, add_v, merge;
  logic [CW-1:0]   wl_ext;
  logic [PW-1:0]   len_m1, p, add_s, add_e, ps, pe;
  logic [AW-1:0]   pe_sum;
  logic signed [XW-1:0] x_ext, on_ext, off_ext;

  assign fire         = s1_valid && room;
  assign sample_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
    if (sample_ready && sample_valid) begin
      s1_sample <= sample;
    end
  end

  // effective last index: length 0 acts as 1, clamp at MAX_WINDOW
  assign wl_ext = CW'(cfg.window_length);
  always_comb begin
    priority if (wl_ext == '0) begin
      len_m1 = '0;
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      len_m1 = PW'(MAX_WINDOW - 1);
    end else begin
      len_m1 = PW'(wl_ext - CW'(1));
    end
  end

  assign last    = (position >= len_m1);
  assign p       = (position > len_m1) ? len_m1 : position;
  assign x_ext   = XW'(s1_sample);
  assign on_ext  = XW'(cfg.start_threshold);
  assign off_ext = XW'(cfg.stop_threshold);

  // open / close decision; at most one region closes per sample
  always_comb begin
    region_open_next = region_open;
    open_start_next  = open_start;
    add_v            = 1'b0;
    add_s            = open_start;
    add_e            = p;
    if (!region_open) begin
      if (x_ext > on_ext) begin
        region_open_next = 1'b1;
        open_start_next  = p;
      end
    end else if (x_ext < off_ext) begin
      region_open_next = 1'b0;
      add_v            = 1'b1;
    end
    if (last && region_open_next) begin
      region_open_next = 1'b0;
      add_v            = 1'b1;
      add_s            = open_start_next;
      add_e            = len_m1;
    end
  end

  // padding
  assign ps     = (AW'(add_s) > AW'(cfg.pre_pad)) ? PW'(AW'(add_s) - AW'(cfg.pre_pad)) : '0;
  assign pe_sum = AW'(add_e) + AW'(cfg.post_pad);
  assign pe     = (pe_sum > AW'(len_m1)) ? len_m1 : PW'(pe_sum);
  assign merge  = pend_v && (ps <= pend_e);

  always_comb begin
    pend_v_next   = pend_v;
    pend_s_next   = pend_s;
    pend_e_next   = pend_e;
    position_next = PW'(p + PW'(1));
    push          = '0;
    if (add_v) begin
      if (merge) begin
        pend_e_next = pe;
      end else begin
        push.v0     = fire && pend_v;
        pend_s_next = ps;
        pend_e_next = pe;
        pend_v_next = 1'b1;
      end
    end
    push.r0.region_start = IDX_W'(pend_s);
    push.r0.region_end   = IDX_W'(pend_e);
    push.r0.window_done  = 1'b0;
    push.r1.region_start = IDX_W'(pend_s_next);
    push.r1.region_end   = IDX_W'(pend_e_next);
    push.r1.window_done  = 1'b1;
    if (last) begin
      push.v1       = fire && pend_v_next;
      pend_v_next   = 1'b0;
      position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      region_open <= 1'b0;
      pend_v      <= 1'b0;
    end else if (fire) begin
      position    <= position_next;
      region_open <= region_open_next;
      pend_v      <= pend_v_next;
    end
    if (fire) begin
      open_start <= open_start_next;
      pend_s     <= pend_s_next;
      pend_e     <= pend_e_next;
    end
  end

  `SRF_ASSERT_IMPL(a_done_only_at_end, clk, rst, push.v1, fire && last, "window_done beat without window end")
  `SRF_ASSERT_IMPL(a_first_needs_close, clk, rst, push.v0, fire && add_v && !merge, "flush without a new region")
  `SRF_ASSERT_NEXT(a_window_wrap, clk, rst, fire && last, position == '0 && !region_open && !pend_v, "state not cleared at window end")

endmodule

`default_nettype wire

/* sv/srf_fifo.sv */
`default_nettype none

module srf_fifo
  import srf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  output logic         room,
  output region_t      rd_data,
  output logic         rd_valid,
  input  wire logic    rd_ready
);

  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  region_t            mem [DEPTH];
  logic [PTR_W-1:0]   wp, wp1, rp, wp_next, rp_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               w0, w1, pop;
  region_t            d0;

  assign w0 = push.v0 || push.v1;
  assign w1 = push.v0 && push.v1;
  assign d0 = push.v0 ? push.r0 : push.r1;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];
  assign pop      = rd_valid && rd_ready;
  assign room     = (count <= CNT_W'(DEPTH - 2));

  assign wp1 = (wp == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wp + PTR_W'(1));

  always_comb begin
    wp_next = wp;
    if (w1) begin
      wp_next = (wp1 == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wp1 + PTR_W'(1));
    end else if (w0) begin
      wp_next = wp1;
    end
    rp_next = rp;
    if (pop) begin
      rp_next = (rp == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rp + PTR_W'(1));
    end
    count_next = CNT_W'(count + CNT_W'(w0) + CNT_W'(w1) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      count <= count_next;
    end
    if (w0) begin
      mem[wp] <= d0;
    end
    if (w1) begin
      mem[wp1] <= push.r1;
    end
  end

  `SRF_ASSERT(a_no_overflow, clk, rst, count <= CNT_W'(DEPTH), "result queue overflow")
  `SRF_ASSERT_IMPL(a_push_has_room, clk, rst, push.v0 || push.v1, room, "result beat pushed without room")

endmodule

`default_nettype wire

/* sv/signal_region_finder_core.sv */
`default_nettype none

// Hysteresis region finder. Takes one signed sample beat per cycle and
// counts its place in a readout window of window_length samples (0 acts as
// 1, values above MAX_WINDOW act as MAX_WINDOW). A region opens at a sample
// strictly above start_threshold and closes at the first later sample
// strictly below stop_threshold (that sample is its end, and it cannot
// reopen the region); a region open at the last sample closes there. Each
// region is widened by pre_pad / post_pad, clamped to the window, and
// merged with the held region before it when they touch. Results come out
// one region behind, as (region_start, region_end); the last region of a
// window carries window_done. A window with no region gives no beat at all,
// and the last sample may give two beats. Throughput is one sample per
// cycle while the queue has room: a sample waits in the input register,
// the window state updates as it leaves, and results drain through a
// four-entry queue. A sample is only taken from the input register when
// the queue has two free entries, so the input stalls only while the
// result side stalls. Registers sit on an APB port at byte addresses 0x00
// start_threshold, 0x04 stop_threshold, 0x08 pre_pad, 0x0C post_pad, 0x10
// window_length. The user must write them only while no sample is in
// flight (not enforced); a change of window_length takes effect at once.
module signal_region_finder_core
  import srf_pkg::*;
#(
  parameter int MAX_WINDOW   = 8192,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [APB_AW-1:0]              paddr,
  input  wire logic [APB_DW-1:0]              pwdata,
  output logic      [APB_DW-1:0]              prdata,
  output logic                                pready,
  // sample stream
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  // region stream
  output logic      [IDX_W-1:0]               region_start,
  output logic      [IDX_W-1:0]               region_end,
  output logic                                window_done,
  output logic                                region_valid,
  input  wire logic                           region_ready
);

  // two beats per sample at most, so four entries keep a full rate
  localparam int OUT_DEPTH = 4;

  cfg_t    cfg;
  push_t   push;
  logic    room;
  region_t rd_data;

  srf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // window tracking: input register plus registered window state
  srf_track #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .room         (room),
    .push         (push)
  );

  // result queue decouples the output handshake
  srf_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .rd_data  (rd_data),
    .rd_valid (region_valid),
    .rd_ready (region_ready)
  );

  assign region_start = rd_data.region_start;
  assign region_end   = rd_data.region_end;
  assign window_done  = rd_data.window_done;

endmodule

`default_nettype wire

/* dv/signal_region_finder_core_test.sv */
`default_nettype none

// Self-checking bench for the hysteresis region finder.
// Samples go in on a valid/ready stream, regions come out on another, and
// registers are written over APB while the block is idle. Every sample beat
// the block takes is fed to a local region tracker, which queues the regions
// that beat must produce. A monitor pops that queue on every region beat.
module signal_region_finder_core_test;
  import srf_pkg::*;

  localparam int MAX_WIN     = 8192;
  localparam int DRAIN_LIMIT = 4000;   // cycles allowed for results to drain
  localparam int TAIL_CYCLES = 8;      // margin for a sample still in flight

  typedef enum int {LVL_HIGH, LVL_LOW, LVL_MID, LVL_NOISE} level_kind_t;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic signed [THR_W-1:0]  sample;
  logic                     sample_valid;
  logic                     sample_ready;
  logic [IDX_W-1:0]         region_start;
  logic [IDX_W-1:0]         region_end;
  logic                     window_done;
  logic                     region_valid;
  logic                     region_ready;

  signal_region_finder_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .region_start (region_start),
    .region_end   (region_end),
    .window_done  (window_done),
    .region_valid (region_valid),
    .region_ready (region_ready)
  );

  // Shared bench state
  bit idle_on     = 1'b1;   // random gaps on both streams
  int hold_cycles = 0;      // one-shot long stall of the region side
  int mismatches  = 0;

  // Region tracker: shadow registers plus window state, reset values
  cfg_t cfg = '{START_THR_RST, STOP_THR_RST, PAD_RST, PAD_RST, WIN_LEN_RST};
  int       win_pos      = 0;
  bit       region_on    = 1'b0;
  int       region_first = 0;
  bit       held_valid   = 1'b0;
  int       held_start   = 0;
  int       held_end     = 0;
  region_t  exp_regions[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("signal_region_finder_core_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Region tracker
  // ---------------------------------------------------------------------

  // 0 behaves as 1, anything above the max window is clamped.
  function automatic int active_len();
    int l;
    l = int'(cfg.window_length);
    if (l == 0) l = 1;
    if (l > MAX_WIN) l = MAX_WIN;
    return l;
  endfunction

  function automatic void queue_region(input int s, input int e, input bit done);
    region_t r;
    r.region_start = IDX_W'(s);
    r.region_end   = IDX_W'(e);
    r.window_done  = done;
    exp_regions.insert(exp_regions.size(), r);
  endfunction

  // Pad a closed region, then either merge it into the held one or emit
  // the held one and hold this one instead.
  task automatic close_region(input int s, input int e, input int len);
    int ps;
    int pe;
    ps = (s > int'(cfg.pre_pad)) ? s - int'(cfg.pre_pad) : 0;
    pe = e + int'(cfg.post_pad);
    if (pe >= len) pe = len - 1;
    if (held_valid && ps <= held_end) begin
      held_end = pe;
      return;
    end
    if (held_valid) queue_region(held_start, held_end, 1'b0);
    held_start = ps;
    held_end   = pe;
    held_valid = 1'b1;
  endtask

  task automatic track_sample(input logic signed [THR_W-1:0] x);
    int len;
    int p;
    bit window_end;
    len        = active_len();
    p          = win_pos;
    window_end = (p + 1 >= len);
    // window may have been shortened under us
    if (p > len - 1) p = len - 1;

    if (!region_on) begin
      if (x > cfg.start_threshold) begin
        region_on    = 1'b1;
        region_first = p;
      end
    end else if (x < cfg.stop_threshold) begin
      // closing sample never reopens
      region_on = 1'b0;
      close_region(region_first, p, len);
    end

    if (window_end) begin
      if (region_on) begin
        region_on = 1'b0;
        close_region(region_first, len - 1, len);
      end
      if (held_valid) queue_region(held_start, held_end, 1'b1);
      held_valid = 1'b0;
      win_pos    = 0;
    end else begin
      win_pos = p + 1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // APB write: setup, then access; register lands when pready is seen.
  // The shadow copy is updated at once since the block is idle.
  task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_THR: cfg.start_threshold = v[THR_W-1:0];
      REG_STOP_THR:  cfg.stop_threshold  = v[THR_W-1:0];
      REG_PRE_PAD:   cfg.pre_pad         = v[PAD_W-1:0];
      REG_POST_PAD:  cfg.post_pad        = v[PAD_W-1:0];
      REG_WIN_LEN:   cfg.window_length   = v[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int on_lvl, input int off_lvl, input int pre,
                            input int post, input int len);
    reg_write(REG_START_THR, APB_DW'(on_lvl) & 32'hFFFF);
    reg_write(REG_STOP_THR,  APB_DW'(off_lvl) & 32'hFFFF);
    reg_write(REG_PRE_PAD,   APB_DW'(pre) & 32'h1FFF);
    reg_write(REG_POST_PAD,  APB_DW'(post) & 32'h1FFF);
    reg_write(REG_WIN_LEN,   APB_DW'(len) & 32'h3FFF);
  endtask

  // One sample beat. Entered and left on a falling edge; valid is only
  // dropped when a gap is drawn, so it never toggles within one step.
  task automatic send_sample(input logic signed [THR_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    track_sample(s);
    @(negedge clk);
  endtask

  // Let every queued region come out, then wait TAIL_CYCLES more clocks:
  // a sample with no result may still be in flight.
  task automatic wait_for_regions();
    int n;
    sample_valid <= 1'b0;
    n = 0;
    while (exp_regions.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int rand_between(input int a, input int b);
    return a + int'($urandom_range(0, b - a));
  endfunction

  // Sample level relative to the current thresholds. Mostly near the
  // threshold, sometimes at the rail.
  function automatic logic signed [THR_W-1:0] pick_sample(input level_kind_t kind);
    int on_lvl;
    int off_lvl;
    int lo;
    int hi;
    on_lvl  = cfg.start_threshold;
    off_lvl = cfg.stop_threshold;
    case (kind)
      LVL_HIGH: begin
        lo = (on_lvl >= 32767) ? 32767 : on_lvl + 1;
        hi = ($urandom_range(0, 3) == 0 || lo + 300 > 32767) ? 32767 : lo + 300;
        return THR_W'(rand_between(lo, hi));
      end
      LVL_LOW: begin
        hi = (off_lvl <= -32768) ? -32768 : off_lvl - 1;
        lo = ($urandom_range(0, 3) == 0 || hi - 300 < -32768) ? -32768 : hi - 300;
        return THR_W'(rand_between(lo, hi));
      end
      LVL_MID: begin
        if (off_lvl <= on_lvl) return THR_W'(rand_between(off_lvl, on_lvl));
        return THR_W'($urandom);
      end
      default: return THR_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Region side: random ready gaps, plus a one-shot long hold-off
  // ---------------------------------------------------------------------
  initial begin : region_sink
    int wait_n;
    region_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        region_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      wait_n = idle_on ? $urandom_range(0, 4) : 0;
      if (wait_n > 0) begin
        region_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      region_ready <= 1'b1;
      do @(posedge clk); while (!region_valid);
      @(negedge clk);
    end
  end

  // Region beat monitor: compare against the oldest expected region.
  always @(posedge clk) begin
    region_t want;
    if (!rst && region_valid && region_ready) begin
      if (exp_regions.size() == 0) begin
        $display("%0t: unexpected region beat start %0d end %0d done %0b",
                 $time, region_start, region_end, window_done);
        mismatches++;
      end else begin
        want = exp_regions.pop_front();
        if (region_start !== want.region_start) begin
          $display("%0t: region_start expected %0d, got %0d",
                   $time, want.region_start, region_start);
          mismatches++;
        end
        if (region_end !== want.region_end) begin
          $display("%0t: region_end expected %0d, got %0d",
                   $time, want.region_end, region_end);
          mismatches++;
        end
        if (window_done !== want.window_done) begin
          $display("%0t: window_done expected %0b, got %0b",
                   $time, want.window_done, window_done);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset thresholds: exact-threshold samples must not open or close,
  // rails do. Ends by shortening the window below the current position.
  task automatic test_reset_thresholds();
    send_sample(16'sd48);      // equal to start level, stays closed
    send_sample(16'sd49);      // opens
    send_sample(16'sd16);      // equal to stop level, stays open
    send_sample(16'sd15);      // closes
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd17);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(16'sd49);      // left open across the length change
    wait_for_regions();
    reg_write(REG_WIN_LEN, 32'd5);
    send_sample(16'sd20);      // already past the new end: window closes
    wait_for_regions();
  endtask

  // Length 0 acts as 1: every sample is a whole window.
  task automatic test_window_of_one();
    reg_write(REG_WIN_LEN, 32'd0);
    send_sample(16'sd49);
    send_sample(16'sd0);       // empty window, no beat
    wait_for_regions();
    reg_write(REG_WIN_LEN, 32'd1);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    wait_for_regions();
  endtask

  // Padding clamps at 0, touching regions merge, and a region opening on
  // the last sample gives two beats in one step.
  task automatic test_pad_merge();
    set_config(100, 20, 1, 1, 16);
    send_sample(16'sd101);
    send_sample(16'sd19);
    send_sample(16'sd200);
    send_sample(16'sd0);
    send_sample(16'sd20);
    send_sample(16'sd100);
    send_sample(16'sd150);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd101);
    send_sample(16'sd20);
    send_sample(16'sd19);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd32767);
    wait_for_regions();
  endtask

  // Region side held off for a long stretch while samples keep coming,
  // so the result queue fills and the sample side has to stall.
  task automatic test_result_backpressure();
    set_config(0, 0, 0, 0, 6);
    idle_on     = 1'b0;
    hold_cycles = 60;
    for (int i = 0; i < 80; i++)
      send_sample((i % 2 == 0) ? 16'sd1000 : -16'sd1000);
    wait_for_regions();
    idle_on = 1'b1;
  endtask

  // Random bursts above the start level and runs below the stop level,
  // with some mid-band and noise, across a range of settings.
  task automatic test_random_streams();
    int on_lvl;
    int off_lvl;
    int pre;
    int post;
    int len;
    int sent;
    int roll;
    int run;
    level_kind_t kind;
    for (int ph = 0; ph < 10; ph++) begin
      on_lvl  = rand_between(-300, 300);
      off_lvl = on_lvl - rand_between(-50, 200);
      pre     = $urandom_range(0, 6);
      post    = $urandom_range(0, 6);
      len     = $urandom_range(1, 48);
      case (ph)
        0: begin on_lvl = 32767;  off_lvl = -32768; end          // never opens
        1: begin on_lvl = -32768; off_lvl = -32768; end          // only the window end closes
        2: begin
          on_lvl = -32768; off_lvl = 32767;
          pre = 8191; post = 8191;
        end
        3: len = 0;
        4: begin len = $urandom_range(100, 300); pre = $urandom_range(0, 20); end
        default: ;
      endcase
      idle_on = (ph % 4 != 3);
      set_config(on_lvl, off_lvl, pre, post, len);
      sent = 0;
      while (sent < 150) begin
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
          kind = LVL_HIGH;
          run  = $urandom_range(1, 5);
        end else if (roll < 8) begin
          kind = LVL_LOW;
          run  = $urandom_range(1, 6);
        end else if (roll == 8) begin
          kind = LVL_MID;
          run  = $urandom_range(1, 3);
        end else begin
          kind = LVL_NOISE;
          run  = $urandom_range(1, 3);
        end
        repeat (run) begin
          send_sample(pick_sample(kind));
          sent++;
        end
      end
      wait_for_regions();
    end
    idle_on = 1'b1;
  endtask

  // A length above the max acts as the max: a large post_pad clamps the
  // end at the last index of the clamped window (8191). Each held region
  // is then pushed out by shortening the window under it.
  task automatic test_longest_window();
    // finish whatever window the random part left behind
    reg_write(REG_WIN_LEN, 32'd1);
    send_sample(16'sd0);
    wait_for_regions();
    idle_on = 1'b0;
    set_config(100, 50, 8191, 8191, 16383);
    send_sample(16'sd0);
    send_sample(16'sd200);     // opens
    send_sample(16'sd0);       // closes, end padded past the window
    send_sample(16'sd200);     // opens again, merges on close
    send_sample(16'sd49);
    wait_for_regions();
    reg_write(REG_WIN_LEN, 32'd1);
    send_sample(16'sd0);       // past the new end: held region comes out
    wait_for_regions();
    set_config(100, 50, 0, 0, MAX_WIN);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    wait_for_regions();
    reg_write(REG_WIN_LEN, 32'd2);
    send_sample(16'sd200);     // opens on the clamped last index and merges
    wait_for_regions();
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample       = '0;
    sample_valid = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_thresholds();
    test_window_of_one();
    test_pad_merge();
    test_result_backpressure();
    test_random_streams();
    test_longest_window();

    wait_for_regions();
    if (exp_regions.size() != 0) begin
      $display("%0t: %0d expected regions never came out", $time, exp_regions.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("signal_region_finder_core_test OK");
    end else begin
      $display("signal_region_finder_core_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
